// ===== sv/tgss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgss_pkg
// Shared types and constants of the three-gap shell sorter: controller
// states, command and status bundles, gap sequence and register map.
// ----------------------------------------------------------------------------
package tgss_pkg;

  // gap stage codes, walked in order wide, mid, one, then done
  localparam int unsigned STAGE_W = 2;
  localparam logic [STAGE_W-1:0] STAGE_WIDE = 2'd0;
  localparam logic [STAGE_W-1:0] STAGE_MID  = 2'd1;
  localparam logic [STAGE_W-1:0] STAGE_ONE  = 2'd2;
  localparam logic [STAGE_W-1:0] STAGE_DONE = 2'd3;

  // gap values
  localparam int unsigned GAP_W = 4;
  localparam logic [GAP_W-1:0] GAP_WIDE = 4'd11;
  localparam logic [GAP_W-1:0] GAP_MID  = 4'd3;
  localparam logic [GAP_W-1:0] GAP_ONE  = 4'd1;

  // register map, indexed by word
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_SIGNED_CMP = 1'b0;

  // controller states
  typedef enum logic [2:0] {
    S_LOAD,
    S_GAP,
    S_KEY_RD,
    S_KEY_WAIT,
    S_CMP,
    S_PLACE,
    S_EMIT_RD,
    S_EMIT_LD
  } ctrl_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // input beat accepted: store item or mark drop
    logic count_clr;  // array done: clear count, drop flag, stage, index
    logic gap_next;   // move to next gap stage
    logic i_init;     // i = gap
    logic rd_key;     // read store[i], j = i
    logic key_cap;    // key = read data, read store[j-gap]
    logic shift;      // store[j] = read data, j -= gap, read next
    logic place;      // store[j] = key, i += 1
    logic rd_out;     // read store[k]
    logic out_load;   // load output register, k += 1
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic stage_done; // all gap stages used
    logic gap_en;     // count exceeds current gap
    logic i_done;     // i reached count
    logic greater;    // read data above key
    logic j_more;     // after a shift, another compare lies ahead
    logic k_last;     // k on the final item
    logic out_free;   // output register can take a beat
  } sts_t;

  // gap for a stage
  function automatic logic [GAP_W-1:0] gap_of(logic [STAGE_W-1:0] stage);
    logic [GAP_W-1:0] gap;
    unique case (stage)
      STAGE_WIDE: gap = GAP_WIDE;
      STAGE_MID:  gap = GAP_MID;
      STAGE_ONE:  gap = GAP_ONE;
      default:    gap = GAP_ONE;
    endcase
    return gap;
  endfunction

endpackage

// ===== sv/tgss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgss_ctrl
// Sequencer of the sorter: load, gapped insertion passes over the store
// and ordered emit, driving the datapath by commands.
// ----------------------------------------------------------------------------
module tgss_ctrl
  import tgss_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic item_valid_i,
  input  logic last_item_i,
  output logic item_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    item_ready_o = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_item_i) begin
            state_d = S_GAP;
          end
        end
      end
      S_GAP: begin
        if (sts_i.stage_done) begin
          state_d = S_EMIT_RD;
        end else if (sts_i.gap_en) begin
          cmd_o.i_init = 1'b1;
          state_d      = S_KEY_RD;
        end else begin
          cmd_o.gap_next = 1'b1;
        end
      end
      S_KEY_RD: begin
        if (sts_i.i_done) begin
          cmd_o.gap_next = 1'b1;
          state_d        = S_GAP;
        end else begin
          cmd_o.rd_key = 1'b1;
          state_d      = S_KEY_WAIT;
        end
      end
      S_KEY_WAIT: begin
        cmd_o.key_cap = 1'b1;
        state_d       = S_CMP;
      end
      S_CMP: begin
        if (sts_i.greater) begin
          cmd_o.shift = 1'b1;
          state_d     = sts_i.j_more ? S_CMP : S_PLACE;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_KEY_RD;
        end
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = S_KEY_RD;
      end
      S_EMIT_RD: begin
        cmd_o.rd_out = 1'b1;
        state_d      = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.k_last) begin
            cmd_o.count_clr = 1'b1;
            state_d         = S_LOAD;
          end else begin
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

endmodule

// ===== sv/tgss_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgss_dp
// Datapath of the sorter: item store, loop indices, held key, comparator
// and the output register.
// ----------------------------------------------------------------------------
module tgss_dp
  import tgss_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64,
  parameter int unsigned ITEM_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] item_value_i,
  input  logic               signed_cmp_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic signed [31:0] sorted_value_o,
  output logic               last_out_o,
  output logic               overflowed_o,
  output logic               sorted_valid_o,
  input  logic               sorted_ready_i
);

  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned CMP_W = (CNT_W > GAP_W) ? CNT_W : GAP_W;

  logic [ITEM_BITS-1:0] mem_q [MAX_ITEMS];
  logic [ITEM_BITS-1:0] rd_data_q;
  logic [ITEM_BITS-1:0] key_q;
  logic [CNT_W-1:0]     count_q;
  logic                 dropped_q;
  logic [STAGE_W-1:0]   stage_q;
  logic [CMP_W-1:0]     i_q;
  logic [CMP_W-1:0]     j_q;
  logic [CNT_W-1:0]     k_q;
  logic                 out_valid_q;
  logic signed [31:0]   out_value_q;
  logic                 out_last_q;
  logic                 out_drop_q;

  logic [CMP_W-1:0]       gap_w;
  logic [CMP_W-1:0]       n_w;
  logic [CMP_W-1:0]       jm;
  logic [CMP_W-1:0]       jm2;
  logic                   full;
  logic [ITEM_BITS+31:0]  in_ext;
  logic [ITEM_BITS+31:0]  out_ext;
  logic [ITEM_BITS-1:0]   flip;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [ITEM_BITS-1:0]   wr_data;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;

  // index arithmetic
  assign gap_w = CMP_W'(gap_of(stage_q));
  assign n_w   = CMP_W'(count_q);
  assign jm    = j_q - gap_w;
  assign jm2   = jm - gap_w;
  assign full  = (count_q == CNT_W'(MAX_ITEMS));

  // item width adaption, zero fill or truncate
  assign in_ext  = {{ITEM_BITS{1'b0}}, item_value_i};
  assign out_ext = {32'b0, rd_data_q};

  // ordering: signed mode flips the top bit
  assign flip = {signed_cmp_i, {(ITEM_BITS-1){1'b0}}};

  // status
  always_comb begin
    sts_o.stage_done = (stage_q == STAGE_DONE);
    sts_o.gap_en     = (n_w > gap_w);
    sts_o.i_done     = (i_q >= n_w);
    sts_o.greater    = ((rd_data_q ^ flip) > (key_q ^ flip));
    sts_o.j_more     = (jm >= gap_w);
    sts_o.k_last     = (k_q == count_q - CNT_W'(1));
    sts_o.out_free   = !out_valid_q || sorted_ready_i;
  end

  // store port selection
  always_comb begin
    wr_en   = (cmd_i.load && !full) || cmd_i.shift || cmd_i.place;
    wr_addr = cmd_i.load ? count_q[IDX_W-1:0] : j_q[IDX_W-1:0];
    if (cmd_i.load) begin
      wr_data = in_ext[ITEM_BITS-1:0];
    end else if (cmd_i.shift) begin
      wr_data = rd_data_q;
    end else begin
      wr_data = key_q;
    end
    rd_en = cmd_i.rd_key || cmd_i.key_cap || (cmd_i.shift && sts_o.j_more) ||
            cmd_i.rd_out;
    if (cmd_i.rd_key) begin
      rd_addr = i_q[IDX_W-1:0];
    end else if (cmd_i.key_cap) begin
      rd_addr = jm[IDX_W-1:0];
    end else if (cmd_i.shift) begin
      rd_addr = jm2[IDX_W-1:0];
    end else begin
      rd_addr = k_q[IDX_W-1:0];
    end
  end

  // item store, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // held key and loop indices
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_cap) begin
      key_q <= rd_data_q;
    end
    if (cmd_i.i_init) begin
      i_q <= gap_w;
    end else if (cmd_i.place) begin
      i_q <= i_q + CMP_W'(1);
    end
    if (cmd_i.rd_key) begin
      j_q <= i_q;
    end else if (cmd_i.shift) begin
      j_q <= jm;
    end
  end

  // array bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      stage_q   <= STAGE_WIDE;
      k_q       <= '0;
    end else if (cmd_i.count_clr) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      stage_q   <= STAGE_WIDE;
      k_q       <= '0;
    end else begin
      if (cmd_i.load) begin
        if (full) begin
          dropped_q <= 1'b1;
        end else begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if (cmd_i.gap_next) begin
        stage_q <= stage_q + STAGE_W'(1);
      end
      if (cmd_i.out_load) begin
        k_q <= k_q + CNT_W'(1);
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (sorted_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_value_q <= out_ext[31:0];
      out_last_q  <= sts_o.k_last;
      out_drop_q  <= dropped_q;
    end
  end

  assign sorted_value_o = out_value_q;
  assign last_out_o     = out_last_q;
  assign overflowed_o   = out_drop_q;
  assign sorted_valid_o = out_valid_q;

  // fill count stays within the store
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ITEMS))
    else $error("item count beyond store depth");

  // a new beat never overwrites one still waiting
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || sorted_ready_i))
    else $error("output register overwritten");

  // a shift only moves an entry down from a valid slot
  a_shift_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift |-> (j_q >= gap_w && j_q < n_w))
    else $error("shift index out of range");

endmodule

// ===== sv/three_gap_shell_sorter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_gap_shell_sorter_core
// Loads an array beat by beat, shellsorts it with gaps 11, 3 and 1 using
// one single-port-write store and one comparator, then emits it in order.
// Load: one input beat per cycle. Sort: per gap pass, each key is read,
// captured and compared, elements are shifted and the key placed, with
// the one store read port and shared compare serialising it. Emit: each
// result beat is read, then loaded when the output register is free; the
// next array loads while the final beat waits. Reset clears control state
// only; no clearing pass needed.
// ----------------------------------------------------------------------------
module three_gap_shell_sorter_core
  import tgss_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64,
  parameter int unsigned ITEM_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input items
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  logic signed [31:0] item_value_i,
  input  logic               last_item_i,
  // sorted results
  output logic               sorted_valid_o,
  input  logic               sorted_ready_i,
  output logic signed [31:0] sorted_value_o,
  output logic               last_out_o,
  output logic               overflowed_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cmd_t cmd;
  sts_t sts;
  logic signed_cmp_q;
  logic cfg_wr;

  // register write
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_cmp_q <= 1'b1;
    end else if (cfg_wr && paddr[2] == REG_SIGNED_CMP) begin
      signed_cmp_q <= pwdata[0];
    end
  end

  // register read
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_SIGNED_CMP: prdata = {31'b0, signed_cmp_q};
      default:        prdata = '0;
    endcase
  end

  // sequencer
  tgss_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid_i),
    .last_item_i  (last_item_i),
    .item_ready_o (item_ready_o),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // store and compare
  tgss_dp #(
    .MAX_ITEMS (MAX_ITEMS),
    .ITEM_BITS (ITEM_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_value_i   (item_value_i),
    .signed_cmp_i   (signed_cmp_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sorted_value_o (sorted_value_o),
    .last_out_o     (last_out_o),
    .overflowed_o   (overflowed_o),
    .sorted_valid_o (sorted_valid_o),
    .sorted_ready_i (sorted_ready_i)
  );

endmodule
